[src/apq_pkg.sv]
package apq_pkg;

    localparam logic [2:0] MODE_INSERT   = 3'd0;
    localparam logic [2:0] MODE_REMOVE   = 3'd1;
    localparam logic [2:0] MODE_DELETE   = 3'd2;
    localparam logic [2:0] MODE_FAVORITE = 3'd3;
    localparam logic [2:0] MODE_INCREASE = 3'd4;
    localparam logic [2:0] MODE_QUERY    = 3'd5;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_EMPTY  = 3'd1;
    localparam logic [2:0] ST_ABSENT = 3'd2;
    localparam logic [2:0] ST_DUP    = 3'd3;
    localparam logic [2:0] ST_OVF    = 3'd4;

    localparam int ID_BITS     = 5;
    localparam int TOTAL_BITS  = 6;
    localparam int REQ_BITS    = 16;

    // controller to datapath
    typedef struct packed {
        logic latch;      // capture the request beat
        logic rd_item;    // read thread_id entry from memory
        logic rd_head;    // read head entry from memory
        logic rd_next;    // read entry after head
        logic walk_adv;   // advance walk pointer to next link
        logic unlink;     // take request entry out of the list
        logic place_go;   // start placement of request entry
        logic link_ins;   // link after walk pointer
        logic link_head;  // link as new head
        logic link_only;  // link as the only entry
        logic inc_step;   // increment one entry priority
        logic fav_prio;   // load favorite priority
        logic set_status;
        logic [2:0] status;
        logic set_found;
        logic set_rprio;
        logic set_rid;
        logic done;       // present the result beat
    } apq_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [2:0] mode;
        logic       id_ok;       // thread_id in range
        logic       item_valid;
        logic       empty;
        logic       single;
        logic       req_ovf;
        logic       head_max;    // head priority at maximum
        logic       other_max;   // favorite target priority at maximum
        logic       head_less;   // head priority below placement priority
        logic       walk_stop;   // next is head or below placement priority
        logic       sweep_last;
    } apq_stat_t;

endpackage

[src/apq_datapath.sv]
module apq_datapath #(
    parameter int ENTRIES   = 32,
    parameter int PRIO_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [2:0]                          mode,
    input  logic [apq_pkg::ID_BITS-1:0]         thread_id,
    input  logic signed [apq_pkg::REQ_BITS-1:0] priority_req,
    input  apq_pkg::apq_cmd_t                   cmd,
    output apq_pkg::apq_stat_t                  stat,
    output logic                                done,
    output logic [2:0]                          status,
    output logic [apq_pkg::ID_BITS-1:0]         result_id,
    output logic signed [apq_pkg::REQ_BITS-1:0] result_priority,
    output logic                                found,
    output logic [apq_pkg::TOTAL_BITS-1:0]      entry_total,
    output logic [apq_pkg::ID_BITS-1:0]         head_thread
);
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic signed [PRIO_BITS-1:0] PMAX = {1'b0, {(PRIO_BITS-1){1'b1}}};

    // link and priority stores, not reset
    logic signed [PRIO_BITS-1:0] prio_mem [ENTRIES];
    logic [IW-1:0]               next_mem [ENTRIES];
    logic [IW-1:0]               prev_mem [ENTRIES];
    logic [ENTRIES-1:0]          valid_reg;

    logic [2:0]                  mode_reg;
    logic [IW-1:0]               idx_reg;
    logic signed [PRIO_BITS-1:0] req_reg;
    logic                        req_ovf_reg;
    logic                        id_ok_reg;
    logic [IW-1:0]               head_reg;
    logic [CW-1:0]               count_reg;
    logic [IW-1:0]               walk_reg;
    logic signed [PRIO_BITS-1:0] item_prio_reg;
    logic [IW-1:0]               item_next_reg;
    logic [IW-1:0]               item_prev_reg;
    logic signed [PRIO_BITS-1:0] head_prio_reg;
    logic [IW-1:0]               head_next_reg;
    logic [IW-1:0]               head_prev_reg;
    logic signed [PRIO_BITS-1:0] rd_prio_reg;
    logic [IW-1:0]               rd_next_reg;
    logic                        done_reg;
    logic [2:0]                  status_reg;
    logic [apq_pkg::ID_BITS-1:0] rid_reg;
    logic signed [apq_pkg::REQ_BITS-1:0] rprio_reg;
    logic                        found_reg;

    logic [IW-1:0] tidx;
    logic signed [PRIO_BITS-1:0] req_ext;
    logic          req_ovf;
    logic          id_ok;

    // remove max works on the head entry, every other mode on thread_id
    assign tidx  = idx_reg;
    assign id_ok = (32'(thread_id) < ENTRIES);

    // sign-extend or range-check the request priority
    always_comb
    begin
        if (PRIO_BITS >= apq_pkg::REQ_BITS)
        begin
            req_ext = PRIO_BITS'(priority_req);
            req_ovf = 1'b0;
        end
        else
        begin
            req_ext = priority_req[PRIO_BITS-1:0];
            req_ovf = (apq_pkg::REQ_BITS'(req_ext) != priority_req);
        end
    end

    always_comb
    begin
        stat.mode         = mode_reg;
        stat.id_ok        = id_ok_reg;
        stat.item_valid   = id_ok_reg && valid_reg[tidx];
        stat.empty        = (count_reg == '0);
        stat.single       = (count_reg == CW'(1));
        stat.req_ovf      = req_ovf_reg;
        stat.head_max     = (head_prio_reg >= PMAX);
        stat.head_less    = (head_prio_reg < req_reg);
        stat.walk_stop    = (rd_next_reg == head_reg) || (rd_prio_reg < req_reg);
        stat.sweep_last   = (walk_reg == IW'(ENTRIES - 1));
        // favorite overflow uses head priority, or next-of-head when the item is head
        stat.other_max    = (tidx == head_reg) ? (rd_prio_reg >= PMAX)
                                               : (head_prio_reg >= PMAX);
    end

    // main state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            head_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.done;
            if (cmd.unlink)
            begin
                valid_reg[tidx] <= 1'b0;
                if (count_reg <= CW'(1))
                begin
                    count_reg <= '0;
                    head_reg  <= '0;
                end
                else
                begin
                    count_reg <= count_reg - CW'(1);
                    if (head_reg == tidx)
                        head_reg <= item_next_reg;
                end
            end
            if (cmd.link_only || cmd.link_head || cmd.link_ins)
            begin
                valid_reg[tidx] <= 1'b1;
                count_reg <= count_reg + CW'(1);
                if (cmd.link_only || cmd.link_head)
                    head_reg <= tidx;
            end
        end
    end

    // memory writes
    always_ff @(posedge clk)
    begin
        if (cmd.unlink && count_reg > CW'(1))
        begin
            next_mem[item_prev_reg] <= item_next_reg;
            prev_mem[item_next_reg] <= item_prev_reg;
        end
        if (cmd.link_only)
        begin
            prio_mem[tidx] <= req_reg;
            next_mem[tidx] <= tidx;
            prev_mem[tidx] <= tidx;
        end
        if (cmd.link_head)
        begin
            // insert after head's predecessor
            prio_mem[tidx] <= req_reg;
            prev_mem[tidx] <= head_prev_reg;
            next_mem[tidx] <= head_reg;
            prev_mem[head_reg] <= tidx;
            next_mem[head_prev_reg] <= tidx;
        end
        if (cmd.link_ins)
        begin
            prio_mem[tidx] <= req_reg;
            prev_mem[tidx] <= walk_reg;
            next_mem[tidx] <= rd_next_reg;
            prev_mem[rd_next_reg] <= tidx;
            next_mem[walk_reg] <= tidx;
        end
        // age one slot per cycle
        if (cmd.inc_step && valid_reg[walk_reg])
            prio_mem[walk_reg] <= prio_mem[walk_reg] + PRIO_BITS'(1);
    end

    // request capture, reads and result
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            mode_reg    <= mode;
            if (mode == apq_pkg::MODE_REMOVE)
                idx_reg <= head_reg;
            else
                idx_reg <= id_ok ? IW'(thread_id) : '0;
            req_reg     <= req_ext;
            req_ovf_reg <= req_ovf;
            id_ok_reg   <= id_ok;
            rid_reg     <= thread_id;
            rprio_reg   <= '0;
            found_reg   <= 1'b0;
            status_reg  <= apq_pkg::ST_OK;
            walk_reg    <= '0;
        end
        if (cmd.rd_item)
        begin
            item_prio_reg <= prio_mem[tidx];
            item_next_reg <= next_mem[tidx];
            item_prev_reg <= prev_mem[tidx];
        end
        if (cmd.rd_head)
        begin
            head_prio_reg <= prio_mem[head_reg];
            head_next_reg <= next_mem[head_reg];
            head_prev_reg <= prev_mem[head_reg];
        end
        // fetch the priority of the entry after head
        if (cmd.rd_next)
            rd_prio_reg <= prio_mem[head_next_reg];
        if (cmd.place_go)
        begin
            rd_next_reg <= head_next_reg;
            rd_prio_reg <= prio_mem[head_next_reg];
            walk_reg    <= head_reg;
        end
        if (cmd.walk_adv)
        begin
            walk_reg    <= rd_next_reg;
            rd_prio_reg <= prio_mem[next_mem[rd_next_reg]];
            rd_next_reg <= next_mem[rd_next_reg];
        end
        if (cmd.inc_step)
            walk_reg <= walk_reg + IW'(1);
        if (cmd.fav_prio)
            req_reg <= ((tidx == head_reg) ? rd_prio_reg : head_prio_reg) + PRIO_BITS'(1);
        if (cmd.set_status)
            status_reg <= cmd.status;
        if (cmd.set_found)
            found_reg <= 1'b1;
        if (cmd.set_rprio)
            rprio_reg <= apq_pkg::REQ_BITS'(item_prio_reg);
        if (cmd.set_rid)
            rid_reg <= apq_pkg::ID_BITS'(tidx);
    end

    assign done            = done_reg;
    assign status          = status_reg;
    assign result_id       = rid_reg;
    assign result_priority = rprio_reg;
    assign found           = found_reg;
    assign entry_total     = apq_pkg::TOTAL_BITS'(count_reg);
    assign head_thread     = (count_reg != '0) ? apq_pkg::ID_BITS'(head_reg) : '0;

endmodule

[src/apq_ctrl.sv]
module apq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  apq_pkg::apq_stat_t stat,
    output apq_pkg::apq_cmd_t  cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_DECIDE, S_FAVRD, S_FAVCHK, S_UNLINK,
        S_PLACE, S_PREP, S_WALK, S_SWEEP, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;
    logic   rem_reg, rem_next;   // remove max: unlink the head

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        busy_next  = busy_reg;
        rem_next   = rem_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    busy_next  = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd_item = 1'b1;
                cmd.rd_head = 1'b1;
                state_next  = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = S_DONE;
                case (stat.mode)
                    apq_pkg::MODE_INSERT:
                    begin
                        if (!stat.id_ok)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status = apq_pkg::ST_ABSENT;
                        end
                        else if (stat.item_valid)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status = apq_pkg::ST_DUP;
                        end
                        else if (stat.req_ovf)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status = apq_pkg::ST_OVF;
                        end
                        else
                            state_next = S_PLACE;
                    end
                    apq_pkg::MODE_REMOVE:
                    begin
                        if (stat.empty)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status = apq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            rem_next   = 1'b1;
                            state_next = S_UNLINK;
                        end
                    end
                    apq_pkg::MODE_DELETE, apq_pkg::MODE_QUERY:
                    begin
                        if (!stat.item_valid)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status = apq_pkg::ST_ABSENT;
                        end
                        else
                        begin
                            cmd.set_found = 1'b1;
                            cmd.set_rprio = 1'b1;
                            if (stat.mode == apq_pkg::MODE_DELETE)
                                state_next = S_UNLINK;
                        end
                    end
                    apq_pkg::MODE_FAVORITE:
                    begin
                        if (stat.empty)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status = apq_pkg::ST_EMPTY;
                        end
                        else if (!stat.item_valid)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status = apq_pkg::ST_ABSENT;
                        end
                        else if (!stat.single)
                            state_next = S_FAVRD;
                    end
                    apq_pkg::MODE_INCREASE:
                    begin
                        if (!stat.empty)
                        begin
                            if (stat.head_max)
                            begin
                                cmd.set_status = 1'b1;
                                cmd.status = apq_pkg::ST_OVF;
                            end
                            else
                                state_next = S_SWEEP;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_FAVRD:
            begin
                // fetch the entry after head
                cmd.rd_next  = 1'b1;
                cmd.fav_prio = 1'b0;
                state_next   = S_FAVCHK;
            end
            S_FAVCHK:
            begin
                if (stat.other_max)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status = apq_pkg::ST_OVF;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.fav_prio = 1'b1;
                    state_next   = S_UNLINK;
                end
            end
            S_UNLINK:
            begin
                cmd.unlink = 1'b1;
                if (rem_reg)
                begin
                    cmd.set_rid   = 1'b1;
                    cmd.set_rprio = 1'b1;
                end
                rem_next   = 1'b0;
                state_next = (stat.mode == apq_pkg::MODE_FAVORITE) ? S_PREP : S_DONE;
            end
            S_PREP:
            begin
                // reread head after the unlink
                cmd.rd_head = 1'b1;
                state_next  = S_PLACE;
            end
            S_PLACE:
            begin
                if (stat.empty)
                begin
                    cmd.link_only = 1'b1;
                    state_next    = S_DONE;
                end
                else if (stat.head_less)
                begin
                    cmd.link_head = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.place_go = 1'b1;
                    state_next   = S_WALK;
                end
            end
            S_WALK:
            begin
                if (stat.walk_stop)
                begin
                    cmd.link_ins = 1'b1;
                    state_next   = S_DONE;
                end
                else
                    cmd.walk_adv = 1'b1;
            end
            S_SWEEP:
            begin
                cmd.inc_step = 1'b1;
                if (stat.sweep_last)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.done   = 1'b1;
                busy_next  = 1'b0;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // hold state and busy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            rem_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            rem_reg   <= rem_next;
        end
    end

    assign busy = busy_reg;

endmodule

[src/aging_priority_queue.sv]
// Thread ready queue in priority order, FCFS among equal priorities. Pulse
// start with mode, thread_id and priority_req while busy is low; busy rises
// the next cycle, and done strobes for one cycle with the result beat in the
// first cycle after busy falls, which the receiver must take then. Insert
// walks the linked list one entry per cycle through the single link memory
// read path; increase sweeps every slot once.
module aging_priority_queue #(
    parameter int ENTRIES   = 32,
    parameter int PRIO_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  mode,
    input  logic [4:0]  thread_id,
    input  logic signed [15:0] priority_req,
    output logic        done,
    output logic [2:0]  status,
    output logic [4:0]  result_id,
    output logic signed [15:0] result_priority,
    output logic        found,
    output logic [5:0]  entry_total,
    output logic [4:0]  head_thread
);
    apq_pkg::apq_cmd_t  cmd;
    apq_pkg::apq_stat_t stat;

    apq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    apq_datapath #(
        .ENTRIES   (ENTRIES),
        .PRIO_BITS (PRIO_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .mode            (mode),
        .thread_id       (thread_id),
        .priority_req    (priority_req),
        .cmd             (cmd),
        .stat            (stat),
        .done            (done),
        .status          (status),
        .result_id       (result_id),
        .result_priority (result_priority),
        .found           (found),
        .entry_total     (entry_total),
        .head_thread     (head_thread)
    );

endmodule

[src/apq_checker.sv]
module apq_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [2:0] status,
    input logic       found,
    input logic [5:0] entry_total
);
    // accepted beat raises busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("busy not raised");

    // results only come once busy has dropped
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("done while busy");

    // done is a single-cycle strobe
    a_rel: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held");

    // found only with ok status
    a_found: assert property (@(posedge clk) disable iff (!rst_n)
        (done && found) |-> (status == apq_pkg::ST_OK)) else $error("found with error");

    // count never exceeds capacity of thread id space
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        entry_total <= 6'd32) else $error("count overflow");

endmodule

bind aging_priority_queue apq_checker u_apq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .found       (found),
    .entry_total (entry_total)
);

[tb/aging_priority_queue_test.sv]
module aging_priority_queue_test;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]         mode;
        logic [4:0]         thread_id;
        logic signed [15:0] priority_req;
    } op_beat_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [4:0]         result_id;
        logic signed [15:0] result_priority;
        logic               found;
        logic [5:0]         entry_total;
        logic [4:0]         head_thread;
    } reply_beat_t;

    localparam int NUM_THREADS = 32;
    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [2:0] mode;
    logic [4:0] thread_id;
    logic signed [15:0] priority_req;
    logic done;
    logic [2:0] status;
    logic [4:0] result_id;
    logic signed [15:0] result_priority;
    logic found;
    logic [5:0] entry_total;
    logic [4:0] head_thread;

    // shadow of the ready queue: priorities plus FCFS order list
    logic signed [15:0] shadow_prio [NUM_THREADS];
    logic               shadow_valid [NUM_THREADS];
    int                 ready_order [$];

    op_beat_t    pending_ops [$];
    reply_beat_t expected_replies [$];
    int          error_count;
    int          cycle_count;
    int          gap_left;
    bit          hold_for_drain;

    aging_priority_queue i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .mode            (mode),
        .thread_id       (thread_id),
        .priority_req    (priority_req),
        .done            (done),
        .status          (status),
        .result_id       (result_id),
        .result_priority (result_priority),
        .found           (found),
        .entry_total     (entry_total),
        .head_thread     (head_thread)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // place a thread after all entries of equal or higher priority
    function automatic void place_thread(int tid, logic signed [15:0] prio);
        int pos;
        pos = ready_order.size();
        for (int k = 0; k < ready_order.size(); k++)
        begin
            if (shadow_prio[ready_order[k]] < prio)
            begin
                pos = k;
                break;
            end
        end
        shadow_prio[tid] = prio;
        shadow_valid[tid] = 1'b1;
        ready_order.insert(pos, tid);
    endfunction

    function automatic void drop_thread(int tid);
        for (int k = 0; k < ready_order.size(); k++)
        begin
            if (ready_order[k] == tid)
            begin
                ready_order.delete(k);
                break;
            end
        end
        shadow_valid[tid] = 1'b0;
    endfunction

    // advance the shadow queue by one beat and return the reply it yields
    function automatic reply_beat_t apply_op(op_beat_t op);
        reply_beat_t r;
        int tid;
        int other;
        logic signed [15:0] top;
        tid = int'(op.thread_id);
        r = '0;
        r.status = apq_pkg::ST_OK;
        r.result_id = op.thread_id;
        case (op.mode)
            apq_pkg::MODE_INSERT:
            begin
                if (shadow_valid[tid])
                    r.status = apq_pkg::ST_DUP;
                else
                    place_thread(tid, op.priority_req);
            end
            apq_pkg::MODE_REMOVE:
            begin
                if (ready_order.size() == 0)
                    r.status = apq_pkg::ST_EMPTY;
                else
                begin
                    r.result_id = 5'(ready_order[0]);
                    r.result_priority = shadow_prio[ready_order[0]];
                    drop_thread(ready_order[0]);
                end
            end
            apq_pkg::MODE_DELETE:
            begin
                if (!shadow_valid[tid])
                    r.status = apq_pkg::ST_ABSENT;
                else
                begin
                    r.found = 1'b1;
                    r.result_priority = shadow_prio[tid];
                    drop_thread(tid);
                end
            end
            apq_pkg::MODE_FAVORITE:
            begin
                if (ready_order.size() == 0)
                    r.status = apq_pkg::ST_EMPTY;
                else if (!shadow_valid[tid])
                    r.status = apq_pkg::ST_ABSENT;
                else if (ready_order.size() > 1)
                begin
                    other = (ready_order[0] == tid) ? ready_order[1] : ready_order[0];
                    top = shadow_prio[other];
                    if (top == 16'sh7fff)
                        r.status = apq_pkg::ST_OVF;
                    else
                    begin
                        drop_thread(tid);
                        place_thread(tid, top + 16'sd1);
                    end
                end
            end
            apq_pkg::MODE_INCREASE:
            begin
                if (ready_order.size() > 0)
                begin
                    if (shadow_prio[ready_order[0]] == 16'sh7fff)
                        r.status = apq_pkg::ST_OVF;
                    else
                        foreach (ready_order[k])
                            shadow_prio[ready_order[k]] += 16'sd1;
                end
            end
            apq_pkg::MODE_QUERY:
            begin
                if (!shadow_valid[tid])
                    r.status = apq_pkg::ST_ABSENT;
                else
                begin
                    r.found = 1'b1;
                    r.result_priority = shadow_prio[tid];
                end
            end
            default:
            begin
            end
        endcase
        r.entry_total = 6'(ready_order.size());
        r.head_thread = (ready_order.size() != 0) ? 5'(ready_order[0]) : 5'd0;
        return r;
    endfunction

    function automatic void push_op(int m, int tid, int p);
        op_beat_t op;
        op.mode = 3'(m);
        op.thread_id = 5'(tid);
        op.priority_req = 16'(p);
        pending_ops.push_back(op);
    endfunction

    function automatic logic signed [15:0] random_prio();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'(16'sh7ffe - 16'($urandom_range(0, 3)));
            3: return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 12)) - 6);
        endcase
    endfunction

    // drive a beat when the sender's gap has run out
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            mode <= apq_pkg::MODE_INSERT;
            thread_id <= '0;
            priority_req <= '0;
            gap_left <= 0;
        end
        else if (start && !busy)
        begin
            expected_replies.push_back(apply_op(op_beat_t'{mode, thread_id, priority_req}));
            start <= 1'b0;
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 16));
        end
        else if (!start)
        begin
            if (gap_left > 0)
                gap_left <= gap_left - 1;
            else if (pending_ops.size() > 0
                     && !(hold_for_drain && expected_replies.size() > 0))
            begin
                mode <= pending_ops[0].mode;
                thread_id <= pending_ops[0].thread_id;
                priority_req <= pending_ops[0].priority_req;
                start <= 1'b1;
                void'(pending_ops.pop_front());
            end
        end
    end

    // check each reply beat against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_replies.size() == 0)
            begin
                $display("%0t: unexpected reply beat status=%0d id=%0d", $time,
                         status, result_id);
                error_count++;
            end
            else
            begin
                reply_beat_t want;
                want = expected_replies.pop_front();
                if (want !== {status, result_id, result_priority, found,
                              entry_total, head_thread})
                begin
                    $display("%0t: mismatch expected st=%0d id=%0d prio=%0d found=%0d total=%0d head=%0d",
                             $time, want.status, want.result_id, want.result_priority,
                             want.found, want.entry_total, want.head_thread);
                    $display("%0t:          actual   st=%0d id=%0d prio=%0d found=%0d total=%0d head=%0d",
                             $time, status, result_id, result_priority, found,
                             entry_total, head_thread);
                    error_count++;
                end
            end
        end
    end

    // end the run if it hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("aging_priority_queue_test failed");
            $finish;
        end
    end

    initial
    begin
        int r;
        int tid;
        error_count = 0;
        cycle_count = 0;
        hold_for_drain = 1'b0;
        for (int k = 0; k < NUM_THREADS; k++)
        begin
            shadow_valid[k] = 1'b0;
            shadow_prio[k] = '0;
        end
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty cases, extremes, ties, overflow paths
        push_op(apq_pkg::MODE_REMOVE, 7, 0);
        push_op(apq_pkg::MODE_FAVORITE, 3, 0);
        push_op(apq_pkg::MODE_INCREASE, 0, 0);
        push_op(apq_pkg::MODE_QUERY, 31, 0);
        push_op(apq_pkg::MODE_DELETE, 0, 0);
        push_op(apq_pkg::MODE_INSERT, 0, 16'sh7fff);
        push_op(apq_pkg::MODE_FAVORITE, 0, 0);
        push_op(apq_pkg::MODE_INCREASE, 0, 0);
        push_op(apq_pkg::MODE_INSERT, 0, 5);
        push_op(apq_pkg::MODE_INSERT, 31, 16'sh8000);
        push_op(apq_pkg::MODE_INSERT, 5, 16'sh7ffe);
        push_op(apq_pkg::MODE_INSERT, 6, 16'sh7ffe);
        push_op(apq_pkg::MODE_FAVORITE, 6, 0);
        push_op(apq_pkg::MODE_FAVORITE, 31, 0);
        push_op(apq_pkg::MODE_INCREASE, 0, 0);
        push_op(apq_pkg::MODE_QUERY, 31, 0);
        push_op(apq_pkg::MODE_DELETE, 31, 0);
        push_op(6, 9, 16'sh1234);
        push_op(7, 10, 16'shffff);
        push_op(apq_pkg::MODE_REMOVE, 0, 0);
        push_op(apq_pkg::MODE_REMOVE, 0, 0);
        push_op(apq_pkg::MODE_REMOVE, 0, 0);
        push_op(apq_pkg::MODE_REMOVE, 0, 0);

        // random: mostly inserts and pops on a small id set, some noise
        for (int n = 0; n < 1150; n++)
        begin
            r = $urandom_range(0, 99);
            tid = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 11);
            if (r < 40)
                push_op(apq_pkg::MODE_INSERT, tid, random_prio());
            else if (r < 55)
                push_op(apq_pkg::MODE_REMOVE, $urandom_range(0, 31), $urandom);
            else if (r < 65)
                push_op(apq_pkg::MODE_DELETE, tid, $urandom);
            else if (r < 77)
                push_op(apq_pkg::MODE_FAVORITE, tid, $urandom);
            else if (r < 85)
                push_op(apq_pkg::MODE_INCREASE, $urandom_range(0, 31), $urandom);
            else if (r < 97)
                push_op(apq_pkg::MODE_QUERY, tid, $urandom);
            else
                push_op($urandom_range(6, 7), $urandom_range(0, 31), $urandom);
            if (n == 500)
            begin
                // hold the sender off until every reply is back
                wait (pending_ops.size() == 0);
                hold_for_drain = 1'b1;
                wait (expected_replies.size() == 0 && !start);
                hold_for_drain = 1'b0;
            end
        end

        wait (pending_ops.size() == 0 && !start);
        wait (expected_replies.size() == 0);
        repeat (60) @(posedge clk);
        if (error_count == 0 && expected_replies.size() == 0)
            $display("aging_priority_queue_test passed");
        else
            $display("aging_priority_queue_test failed");
        $finish;
    end

endmodule

[sim.f]
src/apq_pkg.sv
src/apq_datapath.sv
src/apq_ctrl.sv
src/aging_priority_queue.sv
src/apq_checker.sv
tb/aging_priority_queue_test.sv
